// ===== rtl/dgwq_pkg.sv =====
package dgwq_pkg;

    // request kinds
    localparam logic [1:0] KIND_ACQUIRE     = 2'd0;
    localparam logic [1:0] KIND_RELEASE     = 2'd1;
    localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;

    // result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_NOT_HELD = 3'd4;
    localparam logic [2:0] ST_ALL_DONE = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_CAP0 = 3'd0;
    localparam logic [2:0] CFG_CAP1 = 3'd1;
    localparam logic [2:0] CFG_CAP2 = 3'd2;
    localparam logic [2:0] CFG_CAP3 = 3'd3;
    localparam logic [2:0] CFG_EXCL = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic clr_idx;    // reset list scan index
        logic inc_idx;    // step list scan index
        logic inc_dev;    // step device, clear index
        logic do_acquire; // perform acquire
        logic do_remove;  // remove entry at index
        logic shift;      // one shift step
        logic emit;       // present result word
        logic emit_done;  // present release-all final word
        logic emit_miss;  // present not held word
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic kind_acq;
        logic kind_rel;
        logic kind_all;
        logic idx_end;    // scan index reached holder count
        logic hit;        // entry at index matches pid
        logic dev_end;    // last device scanned
        logic dev_ok;     // request device in range
        logic shift_end;  // no shift steps left
    } t_sts;

endpackage

// ===== rtl/dgwq_ctrl.sv =====
module dgwq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dgwq_pkg::t_sts  i_sts,
    output dgwq_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_NEXTDEV, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_all;
    logic   n_all;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_all   = r_all;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.clr_idx = 1'b1;
                n_all         = i_sts.kind_all;
                if (i_sts.kind_acq) begin
                    o_cmd.do_acquire = 1'b1;
                    o_cmd.emit       = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_sts.kind_rel) begin
                    if (i_sts.dev_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.emit_miss = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.kind_all) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.idx_end) begin
                    if (r_all) begin
                        n_state = S_NEXTDEV;
                    end else begin
                        o_cmd.emit_miss = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.hit) begin
                    o_cmd.do_remove = 1'b1;
                    o_cmd.emit      = 1'b1;
                    n_state         = S_SHIFT;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = r_all ? S_SCAN : S_IDLE;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_NEXTDEV: begin
                if (i_sts.dev_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.inc_dev = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_DONE: begin
                o_cmd.emit_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_all   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_all   <= n_all;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // a word is emitted only while busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.emit_done || o_cmd.emit_miss) |-> o_busy)
        else $error("word emitted while idle");
    // at most one emit kind per cycle
    a_emit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit, o_cmd.emit_done, o_cmd.emit_miss}))
        else $error("two words in one cycle");
    // load only from idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("load while busy");

endmodule

// ===== rtl/dgwq_dp.sv =====
module dgwq_dp #(
    parameter int NUM_DEVICES  = 4,
    parameter int HOLDER_DEPTH = 8,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dgwq_pkg::t_cmd  i_cmd,
    output dgwq_pkg::t_sts  o_sts,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_pid,
    input  logic [1:0]      i_device,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [3:0]      i_cfg_data,
    output logic            o_valid,
    output logic [2:0]      o_status,
    output logic [1:0]      o_device_out,
    output logic            o_woke_valid,
    output logic [7:0]      o_woke_pid,
    output logic            o_last
);

    localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int HW = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
    localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int HCW = $clog2(HOLDER_DEPTH + 1);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);

    // list storage, shifted one entry per cycle during a removal's shift steps
    logic [7:0]     r_hold [NUM_DEVICES][HOLDER_DEPTH];
    logic [7:0]     r_wait [NUM_DEVICES][WAIT_DEPTH];
    logic [HCW-1:0] r_hcnt [NUM_DEVICES];
    logic [WCW-1:0] r_wcnt [NUM_DEVICES];
    logic [3:0]     r_cap  [4];
    logic [3:0]     r_excl;

    logic [1:0]  r_kind;
    logic [7:0]  r_pid;
    logic [1:0]  r_dev_in;
    logic [DW-1:0] r_dev;
    logic [HCW-1:0] r_idx;
    logic [HCW-1:0] r_sh;    // shift position
    logic [WCW-1:0] r_wsh;   // wait shift position

    logic [DW-1:0] w_dev;
    logic          w_excl;
    logic [3:0]    w_cap;
    logic [HCW-1:0] w_hc;
    logic [WCW-1:0] w_wc;
    logic          w_pop;
    logic          w_hsh_end, w_wsh_end;

    assign w_dev  = r_dev;
    assign w_hc   = r_hcnt[w_dev];
    assign w_wc   = r_wcnt[w_dev];
    assign w_excl = ({30'd0, r_dev_in} < 32'(NUM_DEVICES) || r_kind == dgwq_pkg::KIND_RELEASE_ALL)
                    && (32'(w_dev) < 32'd4) && r_excl[2'(w_dev)];
    assign w_cap  = r_cap[2'(w_dev)];
    assign w_pop  = w_excl && (w_wc != '0);
    assign w_hsh_end = (32'(r_sh) > 32'(w_hc));
    assign w_wsh_end = (32'(r_wsh) > 32'(w_wc));

    // status to controller
    always_comb begin
        o_sts.kind_acq  = (r_kind == dgwq_pkg::KIND_ACQUIRE);
        o_sts.kind_rel  = (r_kind == dgwq_pkg::KIND_RELEASE);
        o_sts.kind_all  = (r_kind == dgwq_pkg::KIND_RELEASE_ALL);
        o_sts.dev_ok    = ({30'd0, r_dev_in} < 32'(NUM_DEVICES));
        o_sts.idx_end   = (r_idx >= w_hc);
        o_sts.hit       = (r_idx < w_hc) && (r_hold[w_dev][HW'(r_idx)] == r_pid);
        o_sts.dev_end   = (32'(w_dev) == NUM_DEVICES - 1);
        o_sts.shift_end = w_hsh_end && (r_wsh == '0 || w_wsh_end);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_hcnt[d] <= '0;
                r_wcnt[d] <= '0;
            end
            for (int c = 0; c < 4; c++) r_cap[c] <= 4'd1;
            r_excl  <= '0;
            r_idx   <= '0;
            r_sh    <= '0;
            r_wsh   <= '0;
            r_dev   <= '0;
            o_valid <= 1'b0;
        end else begin
            // result strobe
            o_valid <= i_cmd.do_acquire | i_cmd.do_remove | i_cmd.emit_miss
                       | i_cmd.emit_done;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dgwq_pkg::CFG_CAP0: r_cap[0] <= i_cfg_data;
                    dgwq_pkg::CFG_CAP1: r_cap[1] <= i_cfg_data;
                    dgwq_pkg::CFG_CAP2: r_cap[2] <= i_cfg_data;
                    dgwq_pkg::CFG_CAP3: r_cap[3] <= i_cfg_data;
                    dgwq_pkg::CFG_EXCL: r_excl   <= i_cfg_data;
                    default: ;
                endcase
            end
            // request capture
            if (i_cmd.load) begin
                r_kind   <= i_kind;
                r_pid    <= i_pid;
                r_dev_in <= i_device;
                r_dev    <= (i_kind == dgwq_pkg::KIND_RELEASE_ALL) ? '0 : DW'(i_device);
            end
            if (i_cmd.clr_idx) r_idx <= '0;
            if (i_cmd.inc_idx) r_idx <= r_idx + 1'b1;
            if (i_cmd.inc_dev) begin
                r_dev <= r_dev + 1'b1;
                r_idx <= '0;
            end
            // acquire
            if (i_cmd.do_acquire) begin
                o_device_out <= r_dev_in;
                o_woke_valid <= 1'b0;
                o_woke_pid   <= '0;
                o_last       <= 1'b1;
                if (!o_sts.dev_ok) begin
                    o_status <= dgwq_pkg::ST_REJECTED;
                end else if (w_excl && ({{(32-HCW){1'b0}}, w_hc} >= 32'(w_cap))) begin
                    if (32'(w_wc) >= WAIT_DEPTH) begin
                        o_status <= dgwq_pkg::ST_REJECTED;
                    end else begin
                        r_wait[w_dev][WW'(w_wc)] <= r_pid;
                        r_wcnt[w_dev] <= w_wc + 1'b1;
                        o_status <= dgwq_pkg::ST_QUEUED;
                    end
                end else if (32'(w_hc) >= HOLDER_DEPTH) begin
                    o_status <= dgwq_pkg::ST_REJECTED;
                end else begin
                    r_hold[w_dev][HW'(w_hc)] <= r_pid;
                    r_hcnt[w_dev] <= w_hc + 1'b1;
                    o_status <= dgwq_pkg::ST_GRANTED;
                end
            end
            // removal: report and start shifts
            if (i_cmd.do_remove) begin
                o_status     <= dgwq_pkg::ST_RELEASED;
                o_device_out <= 2'(w_dev);
                o_woke_valid <= w_pop;
                o_woke_pid   <= w_pop ? r_wait[w_dev][0] : 8'd0;
                o_last       <= (r_kind != dgwq_pkg::KIND_RELEASE_ALL);
                r_hcnt[w_dev] <= w_hc - 1'b1;
                r_sh  <= r_idx + 1'b1;
                if (w_pop) begin
                    r_wcnt[w_dev] <= w_wc - 1'b1;
                    r_wsh <= WCW'(1);
                end else begin
                    r_wsh <= '0;
                end
            end
            // one shift step on each list; counts already reduced
            if (i_cmd.shift) begin
                if (!w_hsh_end) begin
                    r_hold[w_dev][HW'(r_sh - 1'b1)] <= r_hold[w_dev][HW'(r_sh)];
                    r_sh <= r_sh + 1'b1;
                end
                if (r_wsh != '0) begin
                    if (32'(r_wsh) <= 32'(w_wc)) begin
                        r_wait[w_dev][WW'(r_wsh - 1'b1)] <= r_wait[w_dev][WW'(r_wsh)];
                        r_wsh <= r_wsh + 1'b1;
                    end else begin
                        r_wsh <= '0;
                    end
                end
            end
            if (i_cmd.emit_miss) begin
                o_status     <= dgwq_pkg::ST_NOT_HELD;
                o_device_out <= r_dev_in;
                o_woke_valid <= 1'b0;
                o_woke_pid   <= '0;
                o_last       <= 1'b1;
            end
            if (i_cmd.emit_done) begin
                o_status     <= dgwq_pkg::ST_ALL_DONE;
                o_device_out <= '0;
                o_woke_valid <= 1'b0;
                o_woke_pid   <= '0;
                o_last       <= 1'b1;
            end
        end
    end

    // device 0 counts never exceed depth
    a_hcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hcnt[0]) <= HOLDER_DEPTH)
        else $error("holder count overflow");
    a_wcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wcnt[0]) <= WAIT_DEPTH)
        else $error("wait count overflow");
    // woken pid only with a release word
    a_woke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_woke_valid) |-> (o_status == dgwq_pkg::ST_RELEASED))
        else $error("woken pid without release");

endmodule

// ===== rtl/device_grant_wait_queue.sv =====
// acquire: start captures the request, then the decode state applies it and registers the result strobe
// release: decode, a holder scan up to the matching entry, then shift steps on the holder and wait lists
// release-all: one list scan and one shift pass per removed entry on every device
// the scan walks one holder entry per cycle and shifts one entry per cycle
// results are strobed one cycle each; the receiver cannot stall
// synchronous active-low reset empties all lists and loads default configuration
module device_grant_wait_queue #(
    parameter int NUM_DEVICES  = 4,
    parameter int HOLDER_DEPTH = 8,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_pid,
    input  logic [1:0] i_device,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    output logic       o_valid,
    output logic [2:0] o_status,
    output logic [1:0] o_device_out,
    output logic       o_woke_valid,
    output logic [7:0] o_woke_pid,
    output logic       o_last
);

    dgwq_pkg::t_cmd w_cmd;
    dgwq_pkg::t_sts w_sts;

    // sequencer
    dgwq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // lists and result word
    dgwq_dp #(
        .NUM_DEVICES  (NUM_DEVICES),
        .HOLDER_DEPTH (HOLDER_DEPTH),
        .WAIT_DEPTH   (WAIT_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_pid        (i_pid),
        .i_device     (i_device),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_device_out (o_device_out),
        .o_woke_valid (o_woke_valid),
        .o_woke_pid   (o_woke_pid),
        .o_last       (o_last)
    );

endmodule
